// ----- src/hhcb_pkg.sv -----
// shared constants, types and tables for the hubbard column builder
// used by hubbard_hamiltonian_column_builder_top; no dependencies
package hhcb_pkg;

  localparam int MAX_SITES   = 8;
  localparam int BASIS_DEPTH = 16384;
  localparam int MAX_ENTRIES = 2 * MAX_SITES + 1;

  localparam int IDX_W  = 14;
  localparam int CNT_W  = 15;
  localparam int VAL_W  = 28;
  localparam int OCC_W  = 16;
  localparam int SITE_W = 4;
  localparam int U_W    = 24;
  localparam int EC_W   = 5;

  // configuration register indexes
  localparam logic [1:0] REG_SITE_COUNT = 2'd0;
  localparam logic [1:0] REG_ONSITE     = 2'd1;
  localparam logic [1:0] REG_BASIS_CNT  = 2'd2;

  // input kinds
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_BUILD = 1'b1;

  // hop element -1.0 in q.16
  localparam logic signed [VAL_W-1:0] HOP_VALUE = -28'sd65536;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic signed [VAL_W-1:0] val_t;

  // site potential round(i * 65536 / 10)
  function automatic val_t site_pot(input logic [2:0] i);
    val_t v;
    begin
      case (i)
        3'd0: v = 28'sd0;
        3'd1: v = 28'sd6554;
        3'd2: v = 28'sd13107;
        3'd3: v = 28'sd19661;
        3'd4: v = 28'sd26214;
        3'd5: v = 28'sd32768;
        3'd6: v = 28'sd39322;
        default: v = 28'sd45875;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- src/hhcb_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module hhcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/hubbard_hamiltonian_column_builder_top.sv -----
// top level of the hubbard hamiltonian column builder
// depends on hhcb_pkg and hhcb_ram
//
// channel | dir | handshake         | payload
// in_     | in  | in_tvalid/tready  | tuser: action; tdata: entry_index, occupation
// out_    | out | out_tvalid/tready | tdata: column, row, entry_value; tlast; tuser
// cfg_    | in  | cfg_we            | cfg_index, cfg_wdata
//
// a load is written to the table as it is taken. a build reads the pattern,
// sums the diagonal in two phases per site, then visits each site and spin;
// per allowed hop it runs a binary search (read then compare on the single
// table port, up to 15 steps), then closes the search and checks the slot;
// then it emits the entries, each held until the output takes it.
// the table ram port sets the pace. reset is synchronous active low and
// clears control state only; the table is undefined until written.
// a stalled output holds the current entry; no item is taken meanwhile.
module hubbard_hamiltonian_column_builder_top
  import hhcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[13:0], occupation[29:14], zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // column[13:0], row[27:14], entry_value[55:28]
  output logic        out_tlast,  // last_entry
  output logic        out_tuser,  // search_failed
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAT  = 3'd1;
  localparam logic [2:0] S_DIAG = 3'd2;
  localparam logic [2:0] S_HOP  = 3'd3;
  localparam logic [2:0] S_SRD  = 3'd4;
  localparam logic [2:0] S_SCMP = 3'd5;
  localparam logic [2:0] S_CHK  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  // configuration
  logic [SITE_W-1:0]       site_count_r;
  logic signed [U_W-1:0]   onsite_r;
  logic [CNT_W-1:0]        basis_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_count_r  <= SITE_W'(4);
      onsite_r      <= '0;
      basis_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SITE_COUNT: site_count_r  <= cfg_wdata[SITE_W-1:0];
        REG_ONSITE:     onsite_r      <= cfg_wdata;
        REG_BASIS_CNT:  basis_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective site and basis counts
  logic [SITE_W-1:0] ni;
  logic [CNT_W-1:0]  count;
  always_comb begin
    if (site_count_r == '0) ni = SITE_W'(1);
    else if (site_count_r > SITE_W'(MAX_SITES)) ni = SITE_W'(MAX_SITES);
    else ni = site_count_r;
    if (basis_count_r == '0) count = CNT_W'(1);
    else if (basis_count_r > CNT_W'(BASIS_DEPTH)) count = CNT_W'(BASIS_DEPTH);
    else count = basis_count_r;
  end

  // sequencer state
  logic [2:0]       state_r, state_nxt;
  idx_t             col_r;
  logic [OCC_W-1:0] pat_r;
  logic [2:0]       site_r;
  logic             phase_r;
  logic             spin_r;
  val_t             acc_r;
  logic             fail_r;
  logic [OCC_W-1:0] key_r;
  logic [CNT_W-1:0] lo_r, hi_r;
  idx_t             mid_r;

  // sorted entry cells, cell 0 holds the next entry out
  idx_t             cell_row_r  [MAX_ENTRIES];
  logic             cell_diag_r [MAX_ENTRIES];
  logic [EC_W-1:0]  cnt_r;

  // table ram
  logic             ram_we;
  idx_t             ram_addr;
  logic [OCC_W-1:0] ram_rdata;

  hhcb_ram #(.WIDTH(OCC_W), .DEPTH(BASIS_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_tdata[29:14]),
    .rdata (ram_rdata)
  );

  logic in_acc, out_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_EMIT);
  assign out_acc   = out_tvalid && out_tready;

  // site and hop geometry
  logic             site_last;
  logic [2:0]       site_j;
  logic [3:0]       bit_a, bit_b, bit_dn;
  logic             up_b, dn_b, has_hop;
  logic [CNT_W:0]   mid_sum;
  assign site_last = ({1'b0, site_r} == ni - SITE_W'(1));
  assign site_j    = site_last ? 3'd0 : site_r + 3'd1;
  assign bit_a     = {1'b0, site_r} + (spin_r ? ni : 4'd0);
  assign bit_b     = {1'b0, site_j} + (spin_r ? ni : 4'd0);
  assign bit_dn    = {1'b0, site_r} + ni;
  assign up_b      = pat_r[bit_a];
  assign dn_b      = pat_r[bit_dn];
  assign has_hop   = pat_r[bit_a] != pat_r[bit_b];
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};

  // diagonal term, one adder shared by the two phases
  val_t pot, term;
  always_comb begin
    pot = site_pot(site_r);
    if (!phase_r) begin
      term = (up_b && dn_b) ? (pot <<< 1) : ((up_b || dn_b) ? pot : '0);
    end else begin
      term = (up_b && dn_b) ? VAL_W'(onsite_r) : '0;
    end
  end

  // insertion control
  logic ins_en, ins_diag;
  idx_t ins_row;

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_addr  = in_tdata[13:0];
    ins_en    = 1'b0;
    ins_diag  = 1'b0;
    ins_row   = lo_r[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == ACT_LOAD) ram_we = 1'b1;
          else if ({1'b0, in_tdata[13:0]} < count) state_nxt = S_PAT;
        end
      end
      S_PAT:  state_nxt = S_DIAG;
      S_DIAG: begin
        if (phase_r && site_last) begin
          ins_en    = 1'b1;
          ins_diag  = 1'b1;
          ins_row   = col_r;
          state_nxt = S_HOP;
        end
      end
      S_HOP: begin
        if (has_hop) state_nxt = S_SRD;
        else if (site_last && spin_r) state_nxt = S_EMIT;
      end
      S_SRD: begin
        if (lo_r < hi_r) begin
          ram_addr  = mid_sum[IDX_W:1];
          state_nxt = S_SCMP;
        end else if (lo_r < count) begin
          ram_addr  = lo_r[IDX_W-1:0];
          state_nxt = S_CHK;
        end else if (site_last && spin_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_HOP;
        end
      end
      S_SCMP: state_nxt = S_SRD;
      S_CHK: begin
        ins_en    = (ram_rdata == key_r);
        state_nxt = (site_last && spin_r) ? S_EMIT : S_HOP;
      end
      S_EMIT: begin
        if (out_acc && cnt_r == EC_W'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // a hop is settled here when its search found or missed, ran past the table, or no hop is allowed
  logic hop_done;
  assign hop_done = (state_r == S_CHK) ||
                    (state_r == S_SRD && !(lo_r < hi_r) && !(lo_r < count)) ||
                    (state_r == S_HOP && !has_hop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      fail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_tuser == ACT_BUILD) begin
        fail_r <= 1'b0;
      end else if (state_r == S_CHK && ram_rdata != key_r) begin
        fail_r <= 1'b1;
      end else if (state_r == S_SRD && !(lo_r < hi_r) && !(lo_r < count)) begin
        fail_r <= 1'b1;
      end
      if (ins_en) cnt_r <= cnt_r + EC_W'(1);
      else if (out_acc) cnt_r <= cnt_r - EC_W'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) col_r <= in_tdata[13:0];
    unique case (state_r)
      S_PAT: begin
        pat_r   <= ram_rdata;
        site_r  <= '0;
        phase_r <= 1'b0;
        spin_r  <= 1'b0;
        acc_r   <= '0;
      end
      S_DIAG: begin
        acc_r   <= acc_r + term;
        phase_r <= !phase_r;
        if (phase_r) site_r <= site_last ? 3'd0 : site_r + 3'd1;
      end
      S_HOP: begin
        key_r <= pat_r ^ ((OCC_W'(1) << bit_a) | (OCC_W'(1) << bit_b));
        lo_r  <= '0;
        hi_r  <= count;
      end
      S_SRD:  mid_r <= mid_sum[IDX_W:1];
      S_SCMP: begin
        if (ram_rdata < key_r) lo_r <= {1'b0, mid_r} + CNT_W'(1);
        else hi_r <= {1'b0, mid_r};
      end
      default: ;
    endcase
    // step to the next site and spin once a hop is settled
    if (hop_done) begin
      spin_r <= !spin_r;
      if (spin_r) site_r <= site_j;
    end
  end

  // cells: stable insertion (new entry after equal rows) and pop from the front
  logic gt [MAX_ENTRIES];
  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      gt[k] = !(EC_W'(k) < cnt_r) || (cell_row_r[k] > ins_row);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (ins_en) begin
        if (gt[k]) begin
          if (k == 0 || !gt[(k == 0) ? 0 : k-1]) begin
            cell_row_r[k]  <= ins_row;
            cell_diag_r[k] <= ins_diag;
          end else begin
            cell_row_r[k]  <= cell_row_r[(k == 0) ? 0 : k-1];
            cell_diag_r[k] <= cell_diag_r[(k == 0) ? 0 : k-1];
          end
        end
      end else if (out_acc && k < MAX_ENTRIES - 1) begin
        cell_row_r[k]  <= cell_row_r[(k < MAX_ENTRIES - 1) ? k+1 : k];
        cell_diag_r[k] <= cell_diag_r[(k < MAX_ENTRIES - 1) ? k+1 : k];
      end
    end
  end

  // result item from the front cell
  assign out_tdata = {cell_diag_r[0] ? acc_r : HOP_VALUE, cell_row_r[0], col_r};
  assign out_tlast = (cnt_r == EC_W'(1));
  assign out_tuser = fail_r;

`ifndef ASSERT_OFF
  // no item is taken while entries are being delivered
  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while emitting");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == ACT_LOAD) |=> !out_tvalid)
    else $error("result after load");

  // the cell count stays within the column size
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= EC_W'(MAX_ENTRIES))
    else $error("entry count overflow");

  // emitting always has at least the diagonal entry
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("emit with no entries");
`endif

endmodule
